/* hdl/eibt_pkg.sv */
// ----------------------------------------------------------------------------
// eibt_pkg
// Shared types and codes for the expiring identifier blocklist table.
// ----------------------------------------------------------------------------
package eibt_pkg;

  localparam int TABLE_SLOTS_DEF = 64;

  typedef logic [2:0]  opcode_t;
  typedef logic [1:0]  status_t;
  typedef logic [31:0] word_t;
  typedef logic [6:0]  count7_t;

  localparam opcode_t OP_BLOCK  = 3'd0;
  localparam opcode_t OP_REMOVE = 3'd1;
  localparam opcode_t OP_QUERY  = 3'd2;
  localparam opcode_t OP_PRUNE  = 3'd3;
  localparam opcode_t OP_TICK   = 3'd4;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

  localparam word_t MINUTE_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic  valid;
    word_t subject;
    word_t issuer;
    word_t start;
    word_t expiry;
    logic  permanent;
  } slot_entry_t;

  typedef struct packed {
    status_t status;
    logic    is_blocked;
    word_t   entry_issuer;
    word_t   entry_start;
    word_t   entry_expiry;
    logic    entry_permanent;
    count7_t pruned_count;
    count7_t entry_count;
  } result_t;

endpackage

/* hdl/eibt_if.sv */
// ----------------------------------------------------------------------------
// eibt_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface eibt_in_if;
  logic                 valid;
  logic                 ready;
  eibt_pkg::opcode_t    opcode;
  eibt_pkg::word_t      subject_id;
  eibt_pkg::word_t      issuer_id;
  eibt_pkg::word_t      duration_min;

  modport source (output valid, opcode, subject_id, issuer_id, duration_min, input ready);
  modport sink   (input valid, opcode, subject_id, issuer_id, duration_min, output ready);
endinterface

interface eibt_out_if;
  logic                 valid;
  logic                 ready;
  eibt_pkg::status_t    status;
  logic                 is_blocked;
  eibt_pkg::word_t      entry_issuer;
  eibt_pkg::word_t      entry_start;
  eibt_pkg::word_t      entry_expiry;
  logic                 entry_permanent;
  eibt_pkg::count7_t    pruned_count;
  eibt_pkg::count7_t    entry_count;

  modport source (output valid, status, is_blocked, entry_issuer, entry_start, entry_expiry,
                  entry_permanent, pruned_count, entry_count, input ready);
  modport sink   (input valid, status, is_blocked, entry_issuer, entry_start, entry_expiry,
                  entry_permanent, pruned_count, entry_count, output ready);
endinterface

/* hdl/expiring_id_blocklist_table.sv */
// ----------------------------------------------------------------------------
// expiring_id_blocklist_table
// Keyed table of blocked identifiers with a minute counter and expiry.
//
//   Channel   Direction  Handshake     Carries
//   in_chan   sink       valid/ready   opcode, subject_id, issuer_id, duration_min
//   out_chan  source     valid/ready   status, query details, pruned and entry counts
//
// Block, remove, query and prune items scan every slot through the single read
// port of the slot memory, one slot per cycle, and then pass to the update step;
// tick and unused opcodes go straight to the update step.
// Reset is synchronous; afterwards a clearing pass writes every slot, one per
// cycle, and no transaction is accepted meanwhile.
// A result waits in the output register; a new item is accepted while it waits,
// and only the final update step stalls until the output register is free.
// ----------------------------------------------------------------------------
module expiring_id_blocklist_table #(
  parameter int TABLE_SLOTS = eibt_pkg::TABLE_SLOTS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  eibt_in_if.sink     in_chan,
  eibt_out_if.source  out_chan
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int PTR_W = IDX_W + 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [PTR_W-1:0] SLOTS_PTR = PTR_W'(TABLE_SLOTS);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(TABLE_SLOTS - 1);
  localparam int ENTRY_W = $bits(eibt_pkg::slot_entry_t);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic                  pend_r, pend_nxt;
  logic [IDX_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  eibt_pkg::slot_entry_t hit_entry_r, hit_entry_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]      prune_cnt_r, prune_cnt_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  eibt_pkg::word_t       now_r, now_nxt;
  eibt_pkg::opcode_t     op_r, op_nxt;
  eibt_pkg::word_t       subj_r, subj_nxt;
  eibt_pkg::word_t       iss_r, iss_nxt;
  eibt_pkg::word_t       dur_r, dur_nxt;
  logic                  out_valid_r, out_valid_nxt;
  eibt_pkg::result_t     res_r, res_nxt;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [ENTRY_W-1:0]    rd_data;
  eibt_pkg::slot_entry_t rd_entry;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  eibt_pkg::slot_entry_t wr_entry;
  logic [ENTRY_W-1:0]    wr_data;
  logic                  in_ready;

  logic [32:0]           exp_sum;
  eibt_pkg::slot_entry_t new_entry;
  logic                  hit_expired;

  eibt_slot_ram #(
    .DEPTH  (TABLE_SLOTS),
    .DATA_W (ENTRY_W)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_entry = eibt_pkg::slot_entry_t'(rd_data);
  assign wr_data  = wr_entry;

  always_comb begin
    exp_sum = {1'b0, now_r} + {1'b0, dur_r};
    new_entry.valid     = 1'b1;
    new_entry.subject   = subj_r;
    new_entry.issuer    = iss_r;
    new_entry.start     = now_r;
    new_entry.permanent = (dur_r == '0);
    if (dur_r == '0 || exp_sum[32]) begin
      new_entry.expiry = eibt_pkg::MINUTE_MAX;
    end else begin
      new_entry.expiry = exp_sum[31:0];
    end
    hit_expired = !hit_entry_r.permanent && (now_r > hit_entry_r.expiry);
  end

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_entry_nxt  = hit_entry_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    prune_cnt_nxt  = prune_cnt_r;
    cnt_nxt        = cnt_r;
    now_nxt        = now_r;
    op_nxt         = op_r;
    subj_nxt       = subj_r;
    iss_nxt        = iss_r;
    dur_nxt        = dur_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = ptr_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = ptr_r[IDX_W-1:0];
    wr_entry       = '0;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_r + PTR_W'(1);
        if (ptr_r == LAST_PTR) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          op_nxt         = in_chan.opcode;
          subj_nxt       = in_chan.subject_id;
          iss_nxt        = in_chan.issuer_id;
          dur_nxt        = in_chan.duration_min;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          prune_cnt_nxt  = '0;
          pend_nxt       = 1'b0;
          ptr_nxt        = '0;
          if (in_chan.opcode == eibt_pkg::OP_BLOCK || in_chan.opcode == eibt_pkg::OP_REMOVE ||
              in_chan.opcode == eibt_pkg::OP_QUERY || in_chan.opcode == eibt_pkg::OP_PRUNE) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_SCAN: begin
        if (ptr_r != SLOTS_PTR) begin
          rd_en        = 1'b1;
          ptr_nxt      = ptr_r + PTR_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = ptr_r[IDX_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (rd_entry.valid && rd_entry.subject == subj_r && !found_r) begin
            found_nxt     = 1'b1;
            hit_idx_nxt   = pend_idx_r;
            hit_entry_nxt = rd_entry;
          end
          if (!rd_entry.valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pend_idx_r;
          end
          if (op_r == eibt_pkg::OP_PRUNE && rd_entry.valid && !rd_entry.permanent &&
              now_r > rd_entry.expiry) begin
            wr_en          = 1'b1;
            wr_addr        = pend_idx_r;
            wr_entry       = rd_entry;
            wr_entry.valid = 1'b0;
            prune_cnt_nxt  = prune_cnt_r + CNT_W'(1);
          end
          if (ptr_r == SLOTS_PTR) begin
            state_nxt = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        if (!out_valid_r || out_chan.ready) begin
          res_nxt = '0;
          res_nxt.status = eibt_pkg::ST_OK;
          case (op_r)
            eibt_pkg::OP_BLOCK: begin
              wr_entry = new_entry;
              if (found_r) begin
                wr_en   = 1'b1;
                wr_addr = hit_idx_r;
              end else if (free_found_r) begin
                wr_en   = 1'b1;
                wr_addr = free_idx_r;
                cnt_nxt = cnt_r + CNT_W'(1);
              end else begin
                res_nxt.status = eibt_pkg::ST_FULL;
              end
            end
            eibt_pkg::OP_REMOVE: begin
              if (found_r) begin
                wr_en          = 1'b1;
                wr_addr        = hit_idx_r;
                wr_entry       = hit_entry_r;
                wr_entry.valid = 1'b0;
                cnt_nxt        = cnt_r - CNT_W'(1);
              end else begin
                res_nxt.status = eibt_pkg::ST_NOT_FOUND;
              end
            end
            eibt_pkg::OP_QUERY: begin
              if (found_r && !hit_expired) begin
                res_nxt.is_blocked      = 1'b1;
                res_nxt.entry_issuer    = hit_entry_r.issuer;
                res_nxt.entry_start     = hit_entry_r.start;
                res_nxt.entry_expiry    = hit_entry_r.expiry;
                res_nxt.entry_permanent = hit_entry_r.permanent;
              end else begin
                res_nxt.status = eibt_pkg::ST_NOT_FOUND;
              end
            end
            eibt_pkg::OP_PRUNE: begin
              cnt_nxt              = cnt_r - prune_cnt_r;
              res_nxt.pruned_count = 7'(prune_cnt_r);
            end
            eibt_pkg::OP_TICK: begin
              if (now_r != eibt_pkg::MINUTE_MAX) begin
                now_nxt = now_r + 32'd1;
              end
            end
            default: begin
            end
          endcase
          res_nxt.entry_count = 7'(cnt_nxt);
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      ptr_r        <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      prune_cnt_r  <= '0;
      cnt_r        <= '0;
      now_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      pend_r       <= pend_nxt;
      found_r      <= found_nxt;
      free_found_r <= free_found_nxt;
      prune_cnt_r  <= prune_cnt_nxt;
      cnt_r        <= cnt_nxt;
      now_r        <= now_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r  <= pend_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_entry_r <= hit_entry_nxt;
    free_idx_r  <= free_idx_nxt;
    op_r        <= op_nxt;
    subj_r      <= subj_nxt;
    iss_r       <= iss_nxt;
    dur_r       <= dur_nxt;
    res_r       <= res_nxt;
  end

  assign in_chan.ready            = in_ready;
  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = res_r.status;
  assign out_chan.is_blocked      = res_r.is_blocked;
  assign out_chan.entry_issuer    = res_r.entry_issuer;
  assign out_chan.entry_start     = res_r.entry_start;
  assign out_chan.entry_expiry    = res_r.entry_expiry;
  assign out_chan.entry_permanent = res_r.entry_permanent;
  assign out_chan.pruned_count    = res_r.pruned_count;
  assign out_chan.entry_count     = res_r.entry_count;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_SLOTS))
    else $error("Stored entry count exceeds the table size.");

  a_scan_write_prune: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && wr_en) |-> op_r == eibt_pkg::OP_PRUNE)
    else $error("Slot written during a scan that is not a prune.");

  a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_APPLY))
    else $error("Result presented without an update step.");

  a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> now_r >= $past(now_r))
    else $error("Minute counter went backward.");

  a_pending_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_SCAN)
    else $error("Read data pending outside a scan.");

endmodule

/* hdl/eibt_slot_ram.sv */
// ----------------------------------------------------------------------------
// eibt_slot_ram
// Slot storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module eibt_slot_ram #(
  parameter int DEPTH  = eibt_pkg::TABLE_SLOTS_DEF,
  parameter int DATA_W = $bits(eibt_pkg::slot_entry_t),
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
